// File: hdl/cfc_pkg.sv
package cfc_pkg;

   // framing characters
   localparam logic [7:0] CH_START = 8'h21;   // '!'
   localparam logic [7:0] CH_END   = 8'h40;   // '@'
   localparam logic [7:0] CH_COMMA = 8'h2C;   // ','
   localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;   // '9'
   localparam logic [7:0] CH_FOUR  = 8'h34;   // '4'

   // reply codes
   localparam logic [7:0] CODE_ACK = 8'd6;
   localparam logic [7:0] CODE_NAK = 8'd21;

   // checksum text limits
   localparam logic [19:0] TEXT_MAX     = 20'h0FFFF;
   localparam logic [19:0] TEXT_INVALID = 20'hFFFFF;

   localparam logic [7:0] LEN_SAT = 8'hFF;

   // defaults for the top level parameters
   localparam int MAX_FRAME_LEN_DEF = 250;
   localparam int FIELD_COMMAS_DEF  = 5;

   // one finished reply, handed from the parser to the serializer
   typedef struct packed {
      logic       push;
      logic [7:0] cmd;
      logic       ack;
   } reply_req_type;

   // byte position within a four-byte reply
   typedef enum logic [1:0] {
      BEAT_START = 2'd0,
      BEAT_CMD   = 2'd1,
      BEAT_CODE  = 2'd2,
      BEAT_END   = 2'd3
   } reply_beat_type;

endpackage

// File: hdl/cfc_ifs.sv
interface cfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reply_byte;
   logic       reply_last;

   modport source (output valid, output reply_byte, output reply_last, input ready);
   modport sink   (input valid, input reply_byte, input reply_last, output ready);
endinterface

// File: hdl/cfc_parser.sv
module cfc_parser #(
   parameter int MAX_FRAME_LEN = cfc_pkg::MAX_FRAME_LEN_DEF,
   parameter int FIELD_COMMAS  = cfc_pkg::FIELD_COMMAS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   output cfc_pkg::reply_req_type reply_req
);

   localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_LEN);
   localparam logic [2:0] NCOMMAS = 3'(FIELD_COMMAS);

   logic        in_frame_ff,     in_frame_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [7:0]  command_code_ff, command_code_in;
   logic [2:0]  comma_count_ff,  comma_count_in;
   logic [15:0] running_sum_ff,  running_sum_in;
   logic [15:0] covered_sum_ff,  covered_sum_in;
   logic [19:0] text_value_ff,   text_value_in;
   logic        frame_error_ff,  frame_error_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff     <= 1'b0;
         frame_length_ff <= '0;
         command_code_ff <= '0;
         comma_count_ff  <= '0;
         running_sum_ff  <= '0;
         covered_sum_ff  <= '0;
         text_value_ff   <= '0;
         frame_error_ff  <= 1'b0;
      end else if (accept) begin
         in_frame_ff     <= in_frame_in;
         frame_length_ff <= frame_length_in;
         command_code_ff <= command_code_in;
         comma_count_ff  <= comma_count_in;
         running_sum_ff  <= running_sum_in;
         covered_sum_ff  <= covered_sum_in;
         text_value_ff   <= text_value_in;
         frame_error_ff  <= frame_error_in;
      end
   end

   always_comb begin
      logic [16:0] sum_w;
      logic        is_four;
      logic        in_text;
      logic        have_comma;
      logic [19:0] text_x10;
      logic [2:0]  cc_inc;

      in_frame_in     = in_frame_ff;
      frame_length_in = frame_length_ff;
      command_code_in = command_code_ff;
      comma_count_in  = comma_count_ff;
      running_sum_in  = running_sum_ff;
      covered_sum_in  = covered_sum_ff;
      text_value_in   = text_value_ff;
      frame_error_in  = frame_error_ff;
      reply_req       = '0;

      is_four    = (command_code_ff == cfc_pkg::CH_FOUR);
      sum_w      = {1'b0, running_sum_ff} + {9'd0, rx_byte};
      cc_inc     = comma_count_ff + 3'd1;
      text_x10   = (text_value_ff << 3) + (text_value_ff << 1)
                   + {12'd0, rx_byte - cfc_pkg::CH_ZERO};
      have_comma = is_four ? (comma_count_ff != 3'd0) : (comma_count_ff >= NCOMMAS);
      in_text    = have_comma;

      if (rx_byte == cfc_pkg::CH_START) begin
         in_frame_in     = 1'b1;
         frame_length_in = '0;
         command_code_in = '0;
         comma_count_in  = '0;
         running_sum_in  = '0;
         covered_sum_in  = '0;
         text_value_in   = '0;
         frame_error_in  = 1'b0;
      end else if (in_frame_ff) begin
         if (frame_length_ff != cfc_pkg::LEN_SAT) begin
            frame_length_in = frame_length_ff + 8'd1;
         end
         if (frame_length_in >= MAX_LEN) begin
            frame_error_in = 1'b1;
         end

         if (rx_byte == cfc_pkg::CH_END) begin
            in_frame_in = 1'b0;
            if (command_code_ff >= cfc_pkg::CH_ZERO && command_code_ff <= cfc_pkg::CH_FOUR) begin
               // push only on the edge that takes the '@' item
               reply_req.push = accept;
               reply_req.cmd  = command_code_ff;
               reply_req.ack  = !frame_error_in && have_comma
                                && (text_value_ff == {4'd0, covered_sum_ff});
            end
         end else begin
            if (sum_w[16]) begin
               frame_error_in = 1'b1;
            end
            running_sum_in = sum_w[15:0];

            if (frame_length_in == 8'd1) begin
               command_code_in = rx_byte;
            end else if (rx_byte == cfc_pkg::CH_COMMA) begin
               if (is_four) begin
                  covered_sum_in = sum_w[15:0];
                  text_value_in  = '0;
                  if (comma_count_ff < NCOMMAS) begin
                     comma_count_in = cc_inc;
                  end
               end else if (comma_count_ff < NCOMMAS) begin
                  comma_count_in = cc_inc;
                  if (cc_inc == NCOMMAS) begin
                     covered_sum_in = sum_w[15:0];
                     text_value_in  = '0;
                  end
               end else begin
                  text_value_in = cfc_pkg::TEXT_INVALID;
               end
            end else if (in_text) begin
               if (rx_byte >= cfc_pkg::CH_ZERO && rx_byte <= cfc_pkg::CH_NINE) begin
                  if (text_value_ff <= cfc_pkg::TEXT_MAX) begin
                     text_value_in = (text_x10 > cfc_pkg::TEXT_MAX)
                                     ? cfc_pkg::TEXT_INVALID : text_x10;
                  end
               end else begin
                  text_value_in = cfc_pkg::TEXT_INVALID;
               end
            end
         end
      end
   end

endmodule

// File: hdl/cfc_reply.sv
module cfc_reply (
   input  logic                   clock,
   input  logic                   reset,
   input  cfc_pkg::reply_req_type reply_req,
   output logic                   can_accept,
   cfc_rsp_if.source              rsp
);

   // one waiting reply record
   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] pend_cmd_ff,   pend_cmd_in;
   logic       pend_ack_ff,   pend_ack_in;

   // reply being sent
   logic                    cur_valid_ff, cur_valid_in;
   logic [7:0]              cur_cmd_ff,   cur_cmd_in;
   logic                    cur_ack_ff,   cur_ack_in;
   cfc_pkg::reply_beat_type beat_ff,      beat_in;

   logic taken;
   logic load;

   assign can_accept = !pend_valid_ff;
   assign taken      = cur_valid_ff && rsp.ready;
   // record moves up when the serializer is empty or its last byte is taken
   assign load       = pend_valid_ff
                       && (!cur_valid_ff || (taken && beat_ff == cfc_pkg::BEAT_END));

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         cur_valid_ff  <= 1'b0;
         beat_ff       <= cfc_pkg::BEAT_START;
      end else begin
         pend_valid_ff <= pend_valid_in;
         cur_valid_ff  <= cur_valid_in;
         beat_ff       <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_cmd_ff <= pend_cmd_in;
      pend_ack_ff <= pend_ack_in;
      cur_cmd_ff  <= cur_cmd_in;
      cur_ack_ff  <= cur_ack_in;
   end

   // record slot and next beat
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_cmd_in   = pend_cmd_ff;
      pend_ack_in   = pend_ack_ff;
      cur_valid_in  = cur_valid_ff;
      cur_cmd_in    = cur_cmd_ff;
      cur_ack_in    = cur_ack_ff;
      beat_in       = beat_ff;

      if (load) begin
         pend_valid_in = 1'b0;
         cur_valid_in  = 1'b1;
         cur_cmd_in    = pend_cmd_ff;
         cur_ack_in    = pend_ack_ff;
         beat_in       = cfc_pkg::BEAT_START;
      end else if (taken) begin
         unique case (beat_ff)
            cfc_pkg::BEAT_START: beat_in = cfc_pkg::BEAT_CMD;
            cfc_pkg::BEAT_CMD:   beat_in = cfc_pkg::BEAT_CODE;
            cfc_pkg::BEAT_CODE:  beat_in = cfc_pkg::BEAT_END;
            cfc_pkg::BEAT_END: begin
               beat_in      = cfc_pkg::BEAT_START;
               cur_valid_in = 1'b0;
            end
            default:             beat_in = cfc_pkg::BEAT_START;
         endcase
      end

      // slot is empty whenever a push can arrive
      if (reply_req.push) begin
         pend_valid_in = 1'b1;
         pend_cmd_in   = reply_req.cmd;
         pend_ack_in   = reply_req.ack;
      end
   end

   // output byte per beat
   always_comb begin
      rsp.valid      = cur_valid_ff;
      rsp.reply_last = 1'b0;
      unique case (beat_ff)
         cfc_pkg::BEAT_START: rsp.reply_byte = cfc_pkg::CH_START;
         cfc_pkg::BEAT_CMD:   rsp.reply_byte = cur_cmd_ff;
         cfc_pkg::BEAT_CODE:  rsp.reply_byte = cur_ack_ff ? cfc_pkg::CODE_ACK
                                                          : cfc_pkg::CODE_NAK;
         cfc_pkg::BEAT_END: begin
            rsp.reply_byte = cfc_pkg::CH_END;
            rsp.reply_last = 1'b1;
         end
         default:             rsp.reply_byte = cfc_pkg::CH_START;
      endcase
   end

endmodule

// File: hdl/command_frame_checker_top.sv
// Command frame checker. Takes received bytes on req_chan, one item per byte.
// '!' opens a frame and the next byte is the command. Bytes from the command
// up to the checksum comma are summed (16 bits; a carry is an error). For
// commands '0'..'3' the checksum comma is comma number FIELD_COMMAS after the
// command; for '4' it is the last comma seen. The decimal text after that
// comma must equal the sum. On '@', commands '0'..'4' get a four-item reply
// on rsp_chan: '!', command, ACK (6) or NAK (21), '@', with reply_last on '@'.
// Frames reaching MAX_FRAME_LEN bytes, overflowing the sum, missing the
// checksum comma or carrying bad text get NAK. Other commands, and bytes
// outside a frame, produce nothing. Rate: one input byte per clock while the
// reply record slot is free; each reply goes out as four output bytes through
// the reply serializer. One finished reply is held while another is being
// sent; ready drops only while that slot is occupied. After the closing '@'
// is accepted, the reply record is registered in the slot and then loaded
// into the serializer once it is free, and its first byte becomes valid.
module command_frame_checker_top #(
   parameter int MAX_FRAME_LEN = cfc_pkg::MAX_FRAME_LEN_DEF,
   parameter int FIELD_COMMAS  = cfc_pkg::FIELD_COMMAS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cfc_req_if.sink     req_chan,
   cfc_rsp_if.source   rsp_chan
);

   cfc_pkg::reply_req_type reply_req;
   logic                   can_accept;
   logic                   req_accept;

   // ready depends only on the reply slot, never on the payload
   assign req_chan.ready = can_accept;
   assign req_accept     = req_chan.valid && can_accept;

   // frame state: sum, comma count, checksum text, error flag
   cfc_parser #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN),
      .FIELD_COMMAS  (FIELD_COMMAS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .rx_byte   (req_chan.rx_byte),
      .reply_req (reply_req)
   );

   // reply slot plus four-byte serializer
   cfc_reply u_reply (
      .clock      (clock),
      .reset      (reset),
      .reply_req  (reply_req),
      .can_accept (can_accept),
      .rsp        (rsp_chan)
   );

endmodule
